>>> rtl/core/masked_byte_pattern_search_macros.svh
// Assertion macros shared by the checker.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MBPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbps assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbps assertion failed");

`endif

>>> rtl/core/mbps_pkg.sv
package mbps_pkg;

	localparam int BYTE_W     = 8;
	localparam int PAT_BYTES  = 16;
	localparam int OFFSET_W   = 32;
	localparam int REGION_W   = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_REG_W  = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(3);

	localparam logic [OFFSET_W-1:0] OFFSET_SAT = '1;
	localparam logic [REGION_W-1:0] REGION_SAT = '1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_t;
	typedef logic [PAT_BYTES-1:0] care_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

>>> rtl/core/mbps_scan_if.sv
interface mbps_scan_if;
	import mbps_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  region_start;
	logic  search_start;

	modport source (output valid, output data_byte, output region_start,
		output search_start, input ready);
	modport sink (input valid, input data_byte, input region_start,
		input search_start, output ready);
endinterface

>>> rtl/core/mbps_result_if.sv
interface mbps_result_if;
	import mbps_pkg::*;

	logic                valid;
	logic                ready;
	logic                match;
	logic [OFFSET_W-1:0] match_offset;
	logic [REGION_W-1:0] region_index;

	modport source (output valid, output match, output match_offset,
		output region_index, input ready);
	modport sink (input valid, input match, input match_offset,
		input region_index, output ready);
endinterface

>>> rtl/core/mbps_cfg_if.sv
interface mbps_cfg_if;
	import mbps_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mbps_cell.sv
module mbps_cell #(
	parameter int PATTERN_MAX = 16,
	parameter int IDX         = 0,
	localparam int LEN_W      = $clog2(PATTERN_MAX + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mbps_pkg::cell_ctl_t ctl,
	input  mbps_pkg::byte_t    byte_in,
	input  logic               valid_in,
	input  mbps_pkg::pat_t     pattern,
	input  mbps_pkg::care_t    care,
	input  logic [LEN_W-1:0]   len,
	output mbps_pkg::byte_t    byte_q,
	output logic               valid_q,
	output logic               ok
);
	import mbps_pkg::*;

	localparam bit FIRST = (IDX == 0);

	logic             eff_valid;
	logic             in_use;
	logic [LEN_W-1:0] pidx;
	logic [7:0]       pidx_w;
	logic             cared;
	byte_t            pbyte;

	// window slot IDX is compared against pattern byte len-1-IDX
	assign eff_valid = FIRST ? valid_in : (valid_in && !ctl.clear);
	assign in_use    = LEN_W'(IDX) < len;
	assign pidx      = len - LEN_W'(IDX) - LEN_W'(1);
	assign pidx_w    = 8'(pidx);
	assign cared     = (pidx_w < 8'(PAT_BYTES)) && care[pidx_w[3:0]];
	assign pbyte     = pattern[pidx_w[3:0]];
	assign ok        = !in_use || (eff_valid && (!cared || byte_in == pbyte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= eff_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

>>> rtl/core/masked_byte_pattern_search.sv
// Masked byte pattern search.
// scan: one memory byte per request with region_start / search_start flags.
// result: one response per scan byte; match is set only on the byte that
//   completes the first match of the current search, with the region number
//   and the offset of the match start (both saturating), zeros otherwise.
// cfg: register writes (0 pattern_low, 1 pattern_high, 2 care_mask,
//   3 pattern_length); always ready, unknown indexes are dropped. Write only
//   while no scan byte is outstanding.
// Response: registered, valid in the cycle after the byte is taken.
// Throughput: one byte per cycle unless stalled; the byte window is a row of
//   PATTERN_MAX shift cells that each compare their byte in the cycle it is taken.
// A stalled result holds the response register; scan.ready drops only while
//   that register is full and not being taken.
// Reset: pattern cleared, care_mask all ones, length 16 clamped to PATTERN_MAX,
//   window empty, counters and found latch cleared, no response pending.
module masked_byte_pattern_search #(
	parameter int PATTERN_MAX = 16
) (
	input logic      clk,
	input logic      arst_n,
	mbps_scan_if.sink     scan,
	mbps_result_if.source result,
	mbps_cfg_if.sink      cfg
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	care_t                 care_q;
	logic [LEN_REG_W-1:0]  plen_q;

	logic [OFFSET_W-1:0] offset_q;
	logic [REGION_W-1:0] region_q;
	logic                found_q;

	logic                res_valid_q;
	logic                res_match_q;
	logic [OFFSET_W-1:0] res_offset_q;
	logic [REGION_W-1:0] res_region_q;

	logic                take;
	cell_ctl_t           ctl;
	pat_t                pattern;
	logic [7:0]          plen_w;
	logic [7:0]          len_w;
	logic [LEN_W-1:0]    len;
	logic [OFFSET_W-1:0] cur;
	logic [REGION_W-1:0] region_nxt;
	logic                found_eff;
	logic                hit;

	byte_t                  cell_byte  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] cell_valid;
	logic [PATTERN_MAX-1:0] cell_ok;

	assign cfg.ready    = 1'b1;
	assign scan.ready   = !res_valid_q || result.ready;
	assign take         = scan.valid && scan.ready;
	assign ctl.shift    = take;
	assign ctl.clear    = scan.region_start || scan.search_start;
	assign pattern      = {pat_hi_q, pat_lo_q};

	always_comb begin
		plen_w = 8'(plen_q);
		priority if (plen_w == 8'd0) begin
			len_w = 8'd1;
		end else if (plen_w > 8'(PATTERN_MAX)) begin
			len_w = 8'(PATTERN_MAX);
		end else begin
			len_w = plen_w;
		end
	end
	assign len = LEN_W'(len_w);

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		if (k == 0) begin : g_head
			mbps_cell #(.PATTERN_MAX(PATTERN_MAX), .IDX(k)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.byte_in (scan.data_byte),
				.valid_in(1'b1),
				.pattern (pattern),
				.care    (care_q),
				.len     (len),
				.byte_q  (cell_byte[k]),
				.valid_q (cell_valid[k]),
				.ok      (cell_ok[k])
			);
		end else begin : g_body
			mbps_cell #(.PATTERN_MAX(PATTERN_MAX), .IDX(k)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.byte_in (cell_byte[k-1]),
				.valid_in(cell_valid[k-1]),
				.pattern (pattern),
				.care    (care_q),
				.len     (len),
				.byte_q  (cell_byte[k]),
				.valid_q (cell_valid[k]),
				.ok      (cell_ok[k])
			);
		end
	end

	always_comb begin
		priority if (scan.search_start) begin
			region_nxt = '0;
		end else if (scan.region_start && region_q != REGION_SAT) begin
			region_nxt = region_q + REGION_W'(1);
		end else begin
			region_nxt = region_q;
		end
	end

	assign cur       = ctl.clear ? '0 : offset_q;
	assign found_eff = found_q && !scan.search_start;
	assign hit       = !found_eff && (&cell_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '1;
			plen_q   <= LEN_REG_W'(PAT_BYTES);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PATTERN_LOW:    pat_lo_q <= cfg.data;
				REG_PATTERN_HIGH:   pat_hi_q <= cfg.data;
				REG_CARE_MASK:      care_q   <= cfg.data[PAT_BYTES-1:0];
				REG_PATTERN_LENGTH: plen_q   <= cfg.data[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			region_q    <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				offset_q    <= (cur == OFFSET_SAT) ? OFFSET_SAT : cur + OFFSET_W'(1);
				region_q    <= region_nxt;
				found_q     <= found_eff || hit;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_match_q  <= hit;
			res_offset_q <= '0;
			res_region_q <= '0;
			if (hit) begin
				res_offset_q <= (cur == OFFSET_SAT) ? OFFSET_SAT :
					cur - OFFSET_W'(len) + OFFSET_W'(1);
				res_region_q <= region_nxt;
			end
		end
	end

	assign result.valid        = res_valid_q;
	assign result.match        = res_match_q;
	assign result.match_offset = res_offset_q;
	assign result.region_index = res_region_q;

endmodule

>>> rtl/core/mbps_checker.sv
`include "masked_byte_pattern_search_macros.svh"

module mbps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          scan_valid,
	input logic                          scan_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          res_match,
	input logic [mbps_pkg::OFFSET_W-1:0] res_offset,
	input logic [mbps_pkg::REGION_W-1:0] res_region,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);
	import mbps_pkg::*;

	`MBPS_ASSERT_NOW(a_nomatch_zero, res_valid && !res_match,
		res_offset == '0 && res_region == '0)
	`MBPS_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready,
		res_valid && $stable(res_match) && $stable(res_offset) && $stable(res_region))
	`MBPS_ASSERT_NOW(a_no_take_when_blocked, res_valid && !res_ready, !scan_ready)
	`MBPS_ASSERT_NEXT(a_take_gives_result, scan_valid && scan_ready, res_valid)
	`MBPS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.scan_valid(scan.valid),
	.scan_ready(scan.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_match (result.match),
	.res_offset(result.match_offset),
	.res_region(result.region_index),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

>>> tb/masked_byte_pattern_search_tb.sv
`timescale 1ns / 100ps

module masked_byte_pattern_search_tb;
	import mbps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = '1;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int REGION_RUN = 20;

	typedef struct packed {
		logic                match;
		logic [OFFSET_W-1:0] offset;
		logic [REGION_W-1:0] region;
	} search_report_t;

	logic clk;
	logic arst_n;

	mbps_scan_if   scan_bus();
	mbps_result_if result_bus();
	mbps_cfg_if    cfg_bus();

	masked_byte_pattern_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan_bus),
		.result(result_bus),
		.cfg(cfg_bus)
	);

	// search model: registers and scan state
	logic [CFG_DATA_W-1:0] cfg_pat_lo;
	logic [CFG_DATA_W-1:0] cfg_pat_hi;
	care_t                 cfg_care;
	logic [LEN_REG_W-1:0]  cfg_len;
	byte_t                 win_bytes [PAT_BYTES];
	int unsigned           win_fill;
	logic [OFFSET_W-1:0]   next_offset;
	logic [REGION_W-1:0]   region_num;
	bit                    match_latched;

	search_report_t pending_reports [$];

	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned matches_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned idle_cycles = 0;
	bit          scan_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_window();
		for (int k = 0; k < PAT_BYTES; k++)
			win_bytes[k] = '0;
		win_fill = 0;
		next_offset = '0;
	endfunction

	function automatic void model_reset();
		cfg_pat_lo = '0;
		cfg_pat_hi = '0;
		cfg_care = '1;
		cfg_len = LEN_REG_W'(PAT_BYTES);
		clear_window();
		region_num = '0;
		match_latched = 1'b0;
	endfunction

	function automatic int unsigned used_len();
		if (cfg_len == 0)
			return 1;
		if (cfg_len > PAT_BYTES)
			return PAT_BYTES;
		return 32'(cfg_len);
	endfunction

	function automatic byte_t pattern_byte_at(int unsigned i);
		if (i < 8)
			return cfg_pat_lo[8*i +: 8];
		return cfg_pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic search_report_t predict_search_step(byte_t d, logic rs, logic ss);
		int unsigned len;
		logic [OFFSET_W-1:0] cur;
		bit hit;
		search_report_t rep;
		len = used_len();
		if (ss) begin
			match_latched = 1'b0;
			region_num = '0;
			clear_window();
		end else if (rs) begin
			if (region_num != REGION_SAT)
				region_num++;
			clear_window();
		end
		// win_bytes[k] is the byte k positions before the newest
		for (int k = PAT_BYTES - 1; k > 0; k--)
			win_bytes[k] = win_bytes[k-1];
		win_bytes[0] = d;
		if (win_fill < PAT_BYTES)
			win_fill++;
		cur = next_offset;
		if (next_offset != OFFSET_SAT)
			next_offset++;
		hit = !match_latched && (win_fill >= len);
		for (int unsigned i = 0; i < len; i++)
			if (cfg_care[i] && win_bytes[len-1-i] != pattern_byte_at(i))
				hit = 1'b0;
		rep = '0;
		if (hit) begin
			match_latched = 1'b1;
			rep.match = 1'b1;
			rep.offset = (cur == OFFSET_SAT) ? OFFSET_SAT : cur - OFFSET_W'(len - 1);
			rep.region = region_num;
		end
		return rep;
	endfunction

	// result sink backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		result_bus.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		search_report_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_reports.size() == 0) begin
				$error("response with no scan byte pending");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (result_bus.match !== want.match) begin
					$error("match: expected %0d, got %0d", want.match, result_bus.match);
					mismatches++;
				end
				if (result_bus.match_offset !== want.offset) begin
					$error("match_offset: expected %0d, got %0d", want.offset,
						result_bus.match_offset);
					mismatches++;
				end
				if (result_bus.region_index !== want.region) begin
					$error("region_index: expected %0d, got %0d", want.region,
						result_bus.region_index);
					mismatches++;
				end
				if (want.match)
					matches_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (scan_bus.valid && scan_bus.ready) ||
			(result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(byte_t d, logic rs, logic ss);
		if (scan_idle_on && $urandom_range(0, 4) == 0) begin
			scan_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		scan_bus.valid <= 1'b1;
		scan_bus.data_byte <= d;
		scan_bus.region_start <= rs;
		scan_bus.search_start <= ss;
		do @(posedge clk); while (!scan_bus.ready);
		pending_reports.push_back(predict_search_step(d, rs, ss));
		bytes_sent++;
	endtask

	// leaves cfg valid high; caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_PATTERN_LOW:    cfg_pat_lo = value;
			REG_PATTERN_HIGH:   cfg_pat_hi = value;
			REG_CARE_MASK:      cfg_care = value[PAT_BYTES-1:0];
			REG_PATTERN_LENGTH: cfg_len = value[LEN_REG_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic apply_config(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
		logic [CFG_DATA_W-1:0] care_word, logic [CFG_DATA_W-1:0] len_word);
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_CARE_MASK, care_word);
		write_reg(REG_PATTERN_LENGTH, len_word);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic drain_results();
		scan_bus.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// reset pattern is 16 zero bytes, all cared; stream before any flag is region 0
	task automatic test_reset_defaults();
		repeat (17) send_byte(8'h00, 1'b0, 1'b0);
		drain_results();
	endtask

	task automatic test_register_writes();
		apply_config('1, '1, {{48{1'b1}}, 16'h0005}, {{59{1'b1}}, 5'd3});
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		drain_results();
		// unmapped indexes must leave the setup alone
		write_reg(REG_UNMAPPED_LOW, '0);
		write_reg(REG_UNMAPPED_TOP, '0);
		cfg_bus.valid <= 1'b0;
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h5A, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		drain_results();
	endtask

	task automatic test_length_clamp();
		apply_config('0, '0, '1, '0);
		send_byte(8'h01, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		drain_results();
		apply_config('0, '0, '0, {{59{1'b0}}, 5'd31});
		for (int k = 0; k < PAT_BYTES; k++)
			send_byte(byte_t'($urandom), 1'b0, k == 0);
		drain_results();
	endtask

	task automatic test_region_boundary();
		apply_config(64'hCDAB, '0, '1, 64'd2);
		send_byte(8'hAB, 1'b0, 1'b1);
		send_byte(8'hCD, 1'b1, 1'b0);
		send_byte(8'hAB, 1'b0, 1'b0);
		send_byte(8'hCD, 1'b0, 1'b0);
		send_byte(8'hAB, 1'b1, 1'b0);
		send_byte(8'hCD, 1'b0, 1'b0);
		send_byte(8'hAB, 1'b1, 1'b1);
		send_byte(8'hCD, 1'b0, 1'b0);
		drain_results();
	endtask

	task automatic test_search_restart();
		apply_config(64'hAB, '0, '1, 64'd1);
		send_byte(8'hAB, 1'b0, 1'b1);
		send_byte(8'hAB, 1'b0, 1'b1);
		send_byte(8'hAB, 1'b0, 1'b0);
		drain_results();
	endtask

	task automatic test_region_counting();
		apply_config(64'h5A, '0, '1, 64'd1);
		send_byte(8'h00, 1'b0, 1'b1);
		repeat (REGION_RUN) send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'h5A, 1'b1, 1'b0);
		send_byte(8'h5A, 1'b1, 1'b1);
		drain_results();
	endtask

	task automatic randomize_search_config(logic [LEN_REG_W-1:0] len);
		logic [CFG_DATA_W-1:0] care_word;
		logic [CFG_DATA_W-1:0] len_word;
		care_word = {$urandom, $urandom};
		len_word = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: care_word[PAT_BYTES-1:0] = '1;
			1: care_word[PAT_BYTES-1:0] = care_t'($urandom);
			2: care_word[PAT_BYTES-1:0] = care_t'($urandom | $urandom);
			default: care_word[PAT_BYTES-1:0] = '0;
		endcase
		len_word[LEN_REG_W-1:0] = len;
		apply_config({$urandom, $urandom}, {$urandom, $urandom}, care_word, len_word);
	endtask

	// mostly planted patterns with random fill, some corrupted or split, some noise
	task automatic test_random_searches(int unsigned n_items);
		int unsigned first;
		int unsigned len;
		int unsigned prefix;
		int unsigned broken_at;
		int unsigned pick;
		byte_t b;
		logic rs;
		logic ss;
		bit brk;
		first = bytes_sent;
		while (bytes_sent - first < n_items) begin
			len = used_len();
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				ss = ($urandom_range(0, 3) != 0);
				rs = ss ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
				broken_at = (pick == 6) ? $urandom_range(0, len - 1) : PAT_BYTES;
				prefix = $urandom_range(0, 3);
				for (int unsigned i = 0; i < prefix + len; i++) begin
					if (i < prefix)
						b = byte_t'($urandom);
					else if (cfg_care[i-prefix])
						b = pattern_byte_at(i - prefix);
					else
						b = byte_t'($urandom);
					brk = (i >= prefix) && (i - prefix == broken_at);
					if (brk && $urandom_range(0, 1))
						b ^= byte_t'(1 << $urandom_range(0, 7));
					send_byte(b, (i == 0) ? rs : (brk && $urandom_range(0, 1)),
						(i == 0) ? ss : 1'b0);
				end
			end else begin
				repeat ($urandom_range(1, 8))
					send_byte(byte_t'($urandom), $urandom_range(0, 7) == 0,
						$urandom_range(0, 15) == 0);
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		scan_bus.valid <= 1'b0;
		scan_bus.data_byte <= '0;
		scan_bus.region_start <= 1'b0;
		scan_bus.search_start <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		model_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_register_writes();
		test_length_clamp();
		test_region_boundary();
		test_search_restart();
		test_region_counting();

		randomize_search_config(LEN_REG_W'(PAT_BYTES));
		test_random_searches(80);
		randomize_search_config(LEN_REG_W'(1));
		test_random_searches(80);
		repeat (3) begin
			randomize_search_config(LEN_REG_W'($urandom_range(0, 31)));
			test_random_searches(80);
		end
		scan_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		randomize_search_config(LEN_REG_W'($urandom_range(1, PAT_BYTES)));
		test_random_searches(60);
		drain_results();

		$display("Scanned %0d bytes after %0d register writes; %0d responses flagged a match.",
			bytes_sent, reg_writes, matches_seen);
		$display("Covered wildcards, length clamping, region splits, restarts, region counting.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
